/* sv/mic_pkg.sv */
// Shared types and constants for the magnetometer iron calibration block.
package mic_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int SCALE_FRAC_BITS    = 12;
  localparam int SCALE_BITS         = 16;
  localparam int AXES               = 3;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int CFG_ADDR_BITS      = 3;
  localparam int CFG_DATA_BITS      = 32;

  typedef enum logic [0:0] {
    REG_AUTO_CAL = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;
  } mic_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] corr_x;
    logic signed [SAMPLE_BITS-1:0] corr_y;
    logic signed [SAMPLE_BITS-1:0] corr_z;
    logic                          clipped;
  } mic_out_t;

endpackage

/* sv/magnetometer_iron_calibration.sv */
// Magnetometer hard-iron and soft-iron correction with running min/max calibration.
//
// Input channel (in_valid/in_ready/in_data) takes one three-axis raw sample per
// transaction; the result channel (out_valid/out_ready/out_data) returns the
// corrected axes and a clipped flag, one result per input transaction.
// The APB port holds auto_calibrate at address 0 (reset 1); write only while idle.
// With auto_calibrate set, each sample widens the per-axis min/max, then the
// offsets are refreshed and the three soft scales run one after another through
// a shared divider that retires two quotient bits a cycle (per axis a setup state,
// then the step states; an axis whose scale is zero or saturates skips the steps).
// A shared multiplier then corrects one axis at a time (multiply, then saturate).
// With calibration off, the sample skips the min/max, offset and divider steps.
// in_ready is high only in the idle state: a new item is taken only after the last
// one has left the final step.
// The result sits in an output register; a new item is accepted while it waits,
// and a finished item holds in the last step until the register frees.
// Reset clears min, max and offsets to zero, sets every scale to 1.0 and
// auto_calibrate to 1, and leaves the block ready with no result pending.
module magnetometer_iron_calibration #(
  parameter int SCALE_FRAC_BITS = mic_pkg::SCALE_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mic_pkg::mic_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mic_pkg::mic_out_t                    out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mic_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [mic_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [mic_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import mic_pkg::*;

  localparam int S           = SAMPLE_BITS;
  localparam int SPAN_W      = S + 1;
  localparam int TOT_W       = S + 3;
  localparam int DIV_W       = S + 3;
  localparam int NUM_W       = TOT_W + SCALE_FRAC_BITS;
  localparam int CMP_W       = DIV_W + SCALE_BITS;
  localparam int PROD_W      = S + SCALE_BITS;
  localparam int STEP_CYCLES = SCALE_BITS / DIV_BITS_PER_CYCLE;
  localparam int CNT_W       = $clog2(STEP_CYCLES);

  localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(STEP_CYCLES - 1);
  localparam logic [1:0]            AXIS_LAST = 2'(AXES - 1);
  localparam logic [SCALE_BITS-1:0] SCALE_ONE = (SCALE_FRAC_BITS >= SCALE_BITS) ?
                                                {SCALE_BITS{1'b1}} :
                                                SCALE_BITS'(64'd1 << SCALE_FRAC_BITS);
  localparam logic [PROD_W-1:0]     NEG_LIM   = {{(PROD_W-1){1'b0}}, 1'b1} << (S - 1);
  localparam logic [PROD_W-1:0]     POS_LIM   = NEG_LIM - {{(PROD_W-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_OFFSET,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } state_t;

  state_t                  state_r;
  logic [1:0]              axis_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    auto_cal_r;
  logic                    sat_r;
  logic signed [S-1:0]     sample_r [AXES];
  logic signed [S-1:0]     min_r    [AXES];
  logic signed [S-1:0]     max_r    [AXES];
  logic signed [S-1:0]     offset_r [AXES];
  logic [SCALE_BITS-1:0]   scale_r  [AXES];
  logic [DIV_W-1:0]        div_r    [AXES];
  logic signed [S-1:0]     corr_r   [AXES];
  logic [TOT_W-1:0]        total_r;
  logic [DIV_W-1:0]        rem_r;
  logic [SCALE_BITS-1:0]   quo_r;
  logic [SCALE_BITS-1:0]   low_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;
  logic                    out_valid_r;
  mic_out_t                out_data_r;

  logic                    cfg_wr;
  logic signed [S-1:0]     offset_nxt [AXES];
  logic [DIV_W-1:0]        div_nxt    [AXES];
  logic [TOT_W-1:0]        total_nxt;
  logic [NUM_W-1:0]        num;
  logic [DIV_W-1:0]        div_cur;
  logic                    div_ovf;
  logic [DIV_W-1:0]        rem_nxt;
  logic [SCALE_BITS-1:0]   quo_nxt;
  logic [SCALE_BITS-1:0]   low_nxt;
  logic signed [S:0]       diff;
  logic [S-1:0]            mag;
  logic [PROD_W-1:0]       prod_sh;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (cfg_reg_t'(paddr[2]) == REG_AUTO_CAL) ?
                     {{(CFG_DATA_BITS-1){1'b0}}, auto_cal_r} : '0;

  always_comb begin
    logic signed [S:0]     sum;
    logic [SPAN_W-1:0]     span;
    total_nxt = '0;
    for (int i = 0; i < AXES; i++) begin
      sum           = {min_r[i][S-1], min_r[i]} + {max_r[i][S-1], max_r[i]};
      sum           = (sum + {{S{1'b0}}, sum[S]}) >>> 1;
      offset_nxt[i] = sum[S-1:0];
      span          = SPAN_W'({max_r[i][S-1], max_r[i]} - {min_r[i][S-1], min_r[i]});
      div_nxt[i]    = (DIV_W'(span) << 1) + DIV_W'(span);
      total_nxt     = total_nxt + TOT_W'(span);
    end
  end

  assign num     = {total_r, {SCALE_FRAC_BITS{1'b0}}};
  assign div_cur = div_r[axis_r];
  assign div_ovf = CMP_W'(num) >= {div_cur, {SCALE_BITS{1'b0}}};

  always_comb begin
    logic [DIV_W:0] t;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    low_nxt = low_r;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      t       = {rem_nxt, low_nxt[SCALE_BITS-1]};
      low_nxt = low_nxt << 1;
      if (t >= {1'b0, div_cur}) begin
        t       = t - {1'b0, div_cur};
        quo_nxt = {quo_nxt[SCALE_BITS-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[SCALE_BITS-2:0], 1'b0};
      end
      rem_nxt = t[DIV_W-1:0];
    end
  end

  assign diff    = {sample_r[axis_r][S-1], sample_r[axis_r]}
                 - {offset_r[axis_r][S-1], offset_r[axis_r]};
  assign mag     = diff[S] ? S'(-diff) : diff[S-1:0];
  assign prod_sh = prod_r >> SCALE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      cnt_r       <= '0;
      auto_cal_r  <= 1'b1;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        min_r[i]    <= '0;
        max_r[i]    <= '0;
        offset_r[i] <= '0;
        scale_r[i]  <= SCALE_ONE;
      end
    end else begin
      if (cfg_wr && cfg_reg_t'(paddr[2]) == REG_AUTO_CAL) begin
        auto_cal_r <= pwdata[0];
      end
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sample_r[0] <= in_data.mag_x;
            sample_r[1] <= in_data.mag_y;
            sample_r[2] <= in_data.mag_z;
            sat_r       <= 1'b0;
            state_r     <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          axis_r <= '0;
          if (auto_cal_r) begin
            for (int i = 0; i < AXES; i++) begin
              if (sample_r[i] < min_r[i]) begin
                min_r[i] <= sample_r[i];
              end
              if (sample_r[i] > max_r[i]) begin
                max_r[i] <= sample_r[i];
              end
            end
            state_r <= ST_OFFSET;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_OFFSET: begin
          for (int i = 0; i < AXES; i++) begin
            offset_r[i] <= offset_nxt[i];
            div_r[i]    <= div_nxt[i];
          end
          total_r <= total_nxt;
          state_r <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          if (div_cur == '0 || div_ovf) begin
            if (div_cur == '0 && total_r == '0) begin
              scale_r[axis_r] <= '0;
            end else begin
              scale_r[axis_r] <= '1;
              sat_r           <= 1'b1;
            end
            if (axis_r == AXIS_LAST) begin
              axis_r  <= '0;
              state_r <= ST_MUL;
            end else begin
              axis_r  <= axis_r + 2'd1;
            end
          end else begin
            rem_r   <= DIV_W'(num >> SCALE_BITS);
            low_r   <= num[SCALE_BITS-1:0];
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV_STEP;
          end
        end
        ST_DIV_STEP: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          low_r <= low_nxt;
          if (cnt_r == CNT_LAST) begin
            scale_r[axis_r] <= quo_nxt;
            if (axis_r == AXIS_LAST) begin
              axis_r  <= '0;
              state_r <= ST_MUL;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_DIV_INIT;
            end
          end else begin
            cnt_r <= cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(mag) * PROD_W'(scale_r[axis_r]);
          neg_r   <= diff[S];
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (neg_r) begin
            if (prod_sh > NEG_LIM) begin
              corr_r[axis_r] <= {1'b1, {(S-1){1'b0}}};
              sat_r          <= 1'b1;
            end else begin
              corr_r[axis_r] <= S'(-prod_sh);
            end
          end else begin
            if (prod_sh > POS_LIM) begin
              corr_r[axis_r] <= {1'b0, {(S-1){1'b1}}};
              sat_r          <= 1'b1;
            end else begin
              corr_r[axis_r] <= prod_sh[S-1:0];
            end
          end
          if (axis_r == AXIS_LAST) begin
            state_r <= ST_DONE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.corr_x  <= corr_r[0];
            out_data_r.corr_y  <= corr_r[1];
            out_data_r.corr_z  <= corr_r[2];
            out_data_r.clipped <= sat_r;
            out_valid_r        <= 1'b1;
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/mic_checker.sv */
// Port-level checks for the magnetometer iron calibration block, bound to the top level.
module mic_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mic_pkg::mic_out_t out_data,
  input logic              pready
);
  import mic_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without an input transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (.*);
